FILE: hw/rtl/sas_pkg.sv
// Package for the status announcement scheduler.
// Holds action and phrase codes, register indexes, reset values and shared types.
`timescale 1ns / 1ps

package sas_pkg;

    localparam int PHRASE_BITS = 4;
    localparam int CFG_BITS    = 32;
    localparam int INDEX_BITS  = 2;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_STEP  = 2'd1,
        ACT_TAKE  = 2'd2,
        ACT_IDLE  = 2'd3
    } sas_action_t;

    localparam logic [PHRASE_BITS-1:0] PH_NONE       = 4'd0;
    localparam logic [PHRASE_BITS-1:0] PH_JOINING    = 4'd1;
    localparam logic [PHRASE_BITS-1:0] PH_BADPASS    = 4'd2;
    localparam logic [PHRASE_BITS-1:0] PH_NONET      = 4'd3;
    localparam logic [PHRASE_BITS-1:0] PH_CONNECTING = 4'd4;
    localparam logic [PHRASE_BITS-1:0] PH_UNREACH    = 4'd5;
    localparam logic [PHRASE_BITS-1:0] PH_KEYREF     = 4'd6;
    localparam logic [PHRASE_BITS-1:0] PH_READY      = 4'd7;
    localparam logic [PHRASE_BITS-1:0] PH_HELLO      = 4'd8;
    localparam logic [PHRASE_BITS-1:0] PH_CALLEND    = 4'd9;

    localparam logic [1:0] LINK_JOINING = 2'd0;
    localparam logic [1:0] LINK_JOINED  = 2'd1;
    localparam logic [1:0] LINK_BADPASS = 2'd2;
    localparam logic [1:0] LINK_NONET   = 2'd3;

    localparam logic [INDEX_BITS-1:0] CFG_NARRATE_ENABLE = 2'd0;
    localparam logic [INDEX_BITS-1:0] CFG_WINDOW         = 2'd1;
    localparam logic [INDEX_BITS-1:0] CFG_SETTLE         = 2'd2;
    localparam logic [INDEX_BITS-1:0] CFG_UNREACH        = 2'd3;

    localparam logic [CFG_BITS-1:0] WINDOW_RESET  = 32'd600000;
    localparam logic [CFG_BITS-1:0] SETTLE_RESET  = 32'd3000;
    localparam logic [CFG_BITS-1:0] UNREACH_RESET = 32'd30000;

    typedef struct packed {
        logic                narrate_enable;
        logic [CFG_BITS-1:0] narration_window_ms;
        logic [CFG_BITS-1:0] settle_ms;
        logic [CFG_BITS-1:0] unreachable_after_ms;
    } sas_cfg_t;

    typedef struct packed {
        logic key_rejected;
        logic server_connected;
        logic session_live;
        logic woken;
        logic pressed;
        logic hung_up;
    } sas_flags_t;

    function automatic logic is_status_phrase(input logic [PHRASE_BITS-1:0] p);
        return (p >= PH_JOINING) && (p <= PH_READY);
    endfunction

endpackage

FILE: hw/rtl/sas_if.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on sas_pkg for field widths.
`timescale 1ns / 1ps

interface sas_in_if #(
    parameter int TIME_BITS = 48
) ();
    logic                 valid;
    logic                 ready;
    logic [1:0]           action;
    logic [TIME_BITS-1:0] now_ms;
    logic [1:0]           link_status;
    logic                 key_rejected;
    logic                 server_connected;
    logic                 session_live;
    logic                 woken;
    logic                 pressed;
    logic                 hung_up;

    modport source (
        output valid, action, now_ms, link_status, key_rejected, server_connected,
               session_live, woken, pressed, hung_up,
        input  ready
    );
    modport sink (
        input  valid, action, now_ms, link_status, key_rejected, server_connected,
               session_live, woken, pressed, hung_up,
        output ready
    );
endinterface

interface sas_out_if ();
    logic                            valid;
    logic                            ready;
    logic [sas_pkg::PHRASE_BITS-1:0] announcement;

    modport source (output valid, announcement, input ready);
    modport sink (input valid, announcement, output ready);
endinterface

FILE: hw/rtl/sas_cfg_regs.sv
// Configuration register file of the status announcement scheduler.
// Depends on sas_pkg for register indexes, reset values and the sas_cfg_t type.
`timescale 1ns / 1ps

module sas_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [sas_pkg::INDEX_BITS-1:0]   wr_index,
    input  logic [sas_pkg::CFG_BITS-1:0]     wr_data,
    output sas_pkg::sas_cfg_t                cfg
);

    sas_pkg::sas_cfg_t cfg_reg;
    sas_pkg::sas_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                sas_pkg::CFG_NARRATE_ENABLE: cfg_next.narrate_enable       = wr_data[0];
                sas_pkg::CFG_WINDOW:         cfg_next.narration_window_ms  = wr_data;
                sas_pkg::CFG_SETTLE:         cfg_next.settle_ms            = wr_data;
                sas_pkg::CFG_UNREACH:        cfg_next.unreachable_after_ms = wr_data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.narrate_enable       <= 1'b1;
            cfg_reg.narration_window_ms  <= sas_pkg::WINDOW_RESET;
            cfg_reg.settle_ms            <= sas_pkg::SETTLE_RESET;
            cfg_reg.unreachable_after_ms <= sas_pkg::UNREACH_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hw/rtl/sas_core.sv
// Scheduler state and per-item decision logic: status mapping, narration and queueing.
// Depends on sas_pkg for codes, sas_cfg_t and sas_flags_t.
`timescale 1ns / 1ps

module sas_core #(
    parameter int TIME_BITS    = 48,
    parameter int PHRASE_COUNT = 10
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              fire,
    input  sas_pkg::sas_action_t              action,
    input  logic [TIME_BITS-1:0]              now_ms,
    input  logic [1:0]                        link_status,
    input  sas_pkg::sas_flags_t               flags,
    input  sas_pkg::sas_cfg_t                 cfg,
    output logic [sas_pkg::PHRASE_BITS-1:0]   take_phrase
);

    logic                            narrating_reg, narrating_next;
    logic [TIME_BITS-1:0]            end_time_reg, end_time_next;
    logic [sas_pkg::PHRASE_BITS-1:0] status_reg, status_next;
    logic [TIME_BITS-1:0]            since_reg, since_next;
    logic [TIME_BITS-1:0]            join_reg, join_next;
    logic                            was_joined_reg, was_joined_next;
    logic [sas_pkg::PHRASE_BITS-1:0] pending_reg, pending_next;
    logic                            answer_reg, answer_next;
    logic [PHRASE_COUNT-1:0]         mask_reg, mask_next;

    logic [TIME_BITS-1:0]            window;
    logic [TIME_BITS-1:0]            settle;
    logic [TIME_BITS-1:0]            unreach;
    logic                            joined;
    logic [TIME_BITS-1:0]            join_eff;
    logic [TIME_BITS-1:0]            since_eff;
    logic [TIME_BITS-1:0]            start_time;
    logic [sas_pkg::PHRASE_BITS-1:0] st;
    logic                            settled;
    logic                            narr_step;
    logic [sas_pkg::PHRASE_BITS-1:0] pend_a;
    logic [sas_pkg::PHRASE_BITS-1:0] pend_b;

    assign window  = TIME_BITS'(cfg.narration_window_ms);
    assign settle  = TIME_BITS'(cfg.settle_ms);
    assign unreach = TIME_BITS'(cfg.unreachable_after_ms);

    assign joined   = (link_status == sas_pkg::LINK_JOINED);
    assign join_eff = (joined && !was_joined_reg) ? now_ms : join_reg;

    always_comb
    begin
        if (flags.key_rejected)
            st = sas_pkg::PH_KEYREF;
        else if (flags.server_connected)
            st = sas_pkg::PH_READY;
        else if (link_status == sas_pkg::LINK_BADPASS)
            st = sas_pkg::PH_BADPASS;
        else if (link_status == sas_pkg::LINK_NONET)
            st = sas_pkg::PH_NONET;
        else if (link_status == sas_pkg::LINK_JOINING)
            st = sas_pkg::PH_JOINING;
        else if ((now_ms - join_eff) >= unreach)
            st = sas_pkg::PH_UNREACH;
        else
            st = sas_pkg::PH_CONNECTING;
    end

    assign since_eff  = (st != status_reg) ? now_ms : since_reg;
    assign start_time = end_time_reg - window;
    assign narr_step  = narrating_reg && ((now_ms - start_time) < window);
    assign settled    = ((now_ms - since_eff) >= settle) || (st == sas_pkg::PH_READY);

    always_comb
    begin
        pend_a = pending_reg;
        if (sas_pkg::is_status_phrase(pending_reg) && (pending_reg != st))
            pend_a = answer_reg ? st : sas_pkg::PH_NONE;
        pend_b = pend_a;
        if (flags.session_live && !answer_reg)
            pend_b = sas_pkg::PH_NONE;
    end

    always_comb
    begin
        narrating_next  = narrating_reg;
        end_time_next   = end_time_reg;
        status_next     = status_reg;
        since_next      = since_reg;
        join_next       = join_reg;
        was_joined_next = was_joined_reg;
        pending_next    = pending_reg;
        answer_next     = answer_reg;
        mask_next       = mask_reg;
        if (fire)
        begin
            unique case (action)
                sas_pkg::ACT_START:
                begin
                    narrating_next  = cfg.narrate_enable;
                    end_time_next   = now_ms + window;
                    status_next     = sas_pkg::PH_NONE;
                    since_next      = now_ms;
                    join_next       = now_ms;
                    was_joined_next = 1'b0;
                    pending_next    = sas_pkg::PH_NONE;
                    answer_next     = 1'b0;
                    mask_next       = '0;
                end
                sas_pkg::ACT_STEP:
                begin
                    join_next       = join_eff;
                    was_joined_next = joined;
                    status_next     = st;
                    since_next      = since_eff;
                    narrating_next  = narr_step;
                    pending_next    = pend_b;
                    if (narr_step && !flags.session_live && settled &&
                        (pend_b == sas_pkg::PH_NONE) && !mask_reg[st])
                    begin
                        pending_next = st;
                        answer_next  = 1'b0;
                    end
                    if (flags.woken || flags.pressed)
                    begin
                        pending_next = (flags.woken && flags.server_connected) ?
                                       sas_pkg::PH_HELLO : st;
                        answer_next  = 1'b1;
                    end
                    else if (flags.hung_up)
                    begin
                        pending_next = sas_pkg::PH_CALLEND;
                        answer_next  = 1'b1;
                    end
                end
                sas_pkg::ACT_TAKE:
                begin
                    if (sas_pkg::is_status_phrase(pending_reg))
                    begin
                        mask_next = mask_reg | (PHRASE_COUNT'(1) << pending_reg);
                        if (pending_reg == sas_pkg::PH_READY)
                            narrating_next = 1'b0;
                    end
                    pending_next = sas_pkg::PH_NONE;
                    answer_next  = 1'b0;
                end
                default:
                begin
                    pending_next = pending_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            narrating_reg  <= 1'b0;
            end_time_reg   <= TIME_BITS'(sas_pkg::WINDOW_RESET);
            status_reg     <= sas_pkg::PH_NONE;
            since_reg      <= '0;
            join_reg       <= '0;
            was_joined_reg <= 1'b0;
            pending_reg    <= sas_pkg::PH_NONE;
            answer_reg     <= 1'b0;
            mask_reg       <= '0;
        end
        else
        begin
            narrating_reg  <= narrating_next;
            end_time_reg   <= end_time_next;
            status_reg     <= status_next;
            since_reg      <= since_next;
            join_reg       <= join_next;
            was_joined_reg <= was_joined_next;
            pending_reg    <= pending_next;
            answer_reg     <= answer_next;
            mask_reg       <= mask_next;
        end
    end

    assign take_phrase = pending_reg;

    // A queued answer is never empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        answer_reg |-> (pending_reg != sas_pkg::PH_NONE))
        else $error("answer flag set with nothing pending");

    // A take always leaves the queue empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (action == sas_pkg::ACT_TAKE)) |=>
        (pending_reg == sas_pkg::PH_NONE) && !answer_reg)
        else $error("pending phrase survived a take");

    // Only status phrases are ever recorded as narrated.
    assert property (@(posedge clk) disable iff (!rst_n)
        !mask_reg[0] && ((mask_reg >> 8) == '0))
        else $error("non-status phrase recorded as narrated");

    // Taking Ready ends narration.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (action == sas_pkg::ACT_TAKE) && (pending_reg == sas_pkg::PH_READY))
        |=> !narrating_reg)
        else $error("narration continued after Ready was taken");

endmodule

FILE: hw/rtl/status_announcement_scheduler.sv
// Status announcement scheduler: an input register, one pass of decision logic, a result register.
// Take results pass the input register, then the result register; other items give no result.
// Throughput: one item per cycle while no take is held, set by the single update pass in sas_core.
// A result still waiting in the output register holds a following take in the input register,
// and the input waits behind that take; other items pass freely.
// Reset (rst_n, asynchronous, active low) empties both stages and loads the default registers.
// Depends on sas_pkg, sas_if, sas_cfg_regs and sas_core.
`timescale 1ns / 1ps

module status_announcement_scheduler #(
    parameter int TIME_BITS    = 48,
    parameter int PHRASE_COUNT = 10
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [sas_pkg::INDEX_BITS-1:0]  wr_index,
    input  logic [sas_pkg::CFG_BITS-1:0]    wr_data,
    sas_in_if.sink                          item,
    sas_out_if.source                       result
);

    sas_pkg::sas_cfg_t               cfg;
    logic                            s_valid_reg, s_valid_next;
    sas_pkg::sas_action_t            s_action_reg;
    logic [TIME_BITS-1:0]            s_now_reg;
    logic [1:0]                      s_link_reg;
    sas_pkg::sas_flags_t             s_flags_reg;
    logic                            out_valid_reg, out_valid_next;
    logic [sas_pkg::PHRASE_BITS-1:0] out_phrase_reg;
    logic [sas_pkg::PHRASE_BITS-1:0] take_phrase;
    logic                            is_take;
    logic                            out_free;
    logic                            s_adv;
    logic                            in_fire;

    sas_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    sas_core #(
        .TIME_BITS    (TIME_BITS),
        .PHRASE_COUNT (PHRASE_COUNT)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (s_adv),
        .action      (s_action_reg),
        .now_ms      (s_now_reg),
        .link_status (s_link_reg),
        .flags       (s_flags_reg),
        .cfg         (cfg),
        .take_phrase (take_phrase)
    );

    assign is_take    = (s_action_reg == sas_pkg::ACT_TAKE);
    assign out_free   = !out_valid_reg || result.ready;
    assign s_adv      = s_valid_reg && (!is_take || out_free);
    assign item.ready = !s_valid_reg || s_adv;
    assign in_fire    = item.valid && item.ready;

    always_comb
    begin
        s_valid_next = s_valid_reg;
        if (in_fire)
            s_valid_next = 1'b1;
        else if (s_adv)
            s_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s_adv && is_take)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s_valid_reg   <= s_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s_action_reg                 <= sas_pkg::sas_action_t'(item.action);
            s_now_reg                    <= item.now_ms;
            s_link_reg                   <= item.link_status;
            s_flags_reg.key_rejected     <= item.key_rejected;
            s_flags_reg.server_connected <= item.server_connected;
            s_flags_reg.session_live     <= item.session_live;
            s_flags_reg.woken            <= item.woken;
            s_flags_reg.pressed          <= item.pressed;
            s_flags_reg.hung_up          <= item.hung_up;
        end
        if (s_adv && is_take)
        begin
            out_phrase_reg <= take_phrase;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.announcement = out_phrase_reg;

endmodule
